>>> rtl/nbdr_pkg.sv
// Shared types, constants and helpers for the navigation button debounce block.
// Used by every module under rtl/; depends on nothing.
`default_nettype none

package nbdr_pkg;

  localparam int HISTORY_DEPTH = 4;
  localparam int QUEUE_DEPTH   = 4;

  localparam int BTN_W      = 7;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int INTERVAL_W = 10;
  localparam int HOLD_W     = 11;
  localparam int ACCEL_W    = 4;
  localparam int ACTION_W   = 3;
  localparam int NUM_SLOTS  = 6;
  localparam int SLOT_W     = 3;

  // register indexes on the config port
  localparam logic [REG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FLOOR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RPS   = 3'd4;

  localparam logic [INTERVAL_W-1:0] START_RST = 10'd400;
  localparam logic [INTERVAL_W-1:0] FLOOR_RST = 10'd100;
  localparam logic [INTERVAL_W-1:0] STEP_RST  = 10'd100;
  localparam logic [ACCEL_W-1:0]    RPS_RST   = 4'd10;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_INC    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DEC    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LEFT   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RIGHT  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_BACK   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_HOME   = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SELECT = 3'd6;

  // button bit positions
  localparam int BTN_UP = 0;
  localparam int BTN_DN = 1;
  localparam int BTN_LF = 2;
  localparam int BTN_RT = 3;
  localparam int BTN_EN = 4;
  localparam int BTN_BK = 5;
  localparam int BTN_SH = 6;

  // emission slots, in output order
  localparam logic [SLOT_W-1:0] SLOT_INC    = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_DEC    = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_LEFT   = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_RIGHT  = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_SELECT = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_BACK   = 3'd5;

  typedef struct packed {
    logic                  mode;
    logic [INTERVAL_W-1:0] start_interval;
    logic [INTERVAL_W-1:0] floor_interval;
    logic [INTERVAL_W-1:0] interval_step;
    logic [ACCEL_W-1:0]    repeats_per_step;
  } cfg_t;

  // one tick's worth of actions: slot set, back slot becomes home, shift flag
  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    logic                 home;
    logic                 sh;
  } job_t;

  function automatic logic [ACTION_W-1:0] slot_action(input logic [SLOT_W-1:0] slot,
                                                      input logic home);
    logic [ACTION_W-1:0] act;
    case (slot)
      SLOT_INC:    act = ACT_INC;
      SLOT_DEC:    act = ACT_DEC;
      SLOT_LEFT:   act = ACT_LEFT;
      SLOT_RIGHT:  act = ACT_RIGHT;
      SLOT_SELECT: act = ACT_SELECT;
      SLOT_BACK:   act = home ? ACT_HOME : ACT_BACK;
      default:     act = ACT_SELECT;
    endcase
    return act;
  endfunction

endpackage

`default_nettype wire

>>> rtl/nav_button_debounce_repeat_core.sv
// Top level of the navigation button debouncer with accelerating auto-repeat.
// Holds the config registers; instantiates nbdr_front, nbdr_fifo, nbdr_back.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   tick in  | in_valid_i / in_ready_o | raw_levels_i[6:0]
//   action   | out_valid_o/out_ready_i | action_o[2:0], shifted_o, last_o
//   config   | cfg_we_i (no wait)      | cfg_idx_i[2:0], cfg_wdata_i[9:0]
//
// A tick is debounced and timed in the cycle it transfers; its actions
// (0 to 6) leave one per cycle while the output is not stalled. The
// emitter's one-action-per-cycle walk sets the rate; the job queue lets
// ticks keep coming while actions drain. in_ready_o drops only when the
// queue is full. Reset restores register defaults; no clearing pass.
`default_nettype none

module nav_button_debounce_repeat_core #(
  parameter int HISTORY_DEPTH = nbdr_pkg::HISTORY_DEPTH,
  parameter int QUEUE_DEPTH   = nbdr_pkg::QUEUE_DEPTH
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [nbdr_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  wire [nbdr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire [nbdr_pkg::BTN_W-1:0]        raw_levels_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [nbdr_pkg::ACTION_W-1:0]    action_o,
  output logic                             shifted_o,
  output logic                             last_o
);

  nbdr_pkg::cfg_t  cfg_q, cfg_d;
  nbdr_pkg::job_t  push_job, head_job;
  logic            push, pop, fifo_empty, fifo_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        nbdr_pkg::REG_MODE:  cfg_d.mode             = cfg_wdata_i[0];
        nbdr_pkg::REG_START: cfg_d.start_interval   = cfg_wdata_i;
        nbdr_pkg::REG_FLOOR: cfg_d.floor_interval   = cfg_wdata_i;
        nbdr_pkg::REG_STEP:  cfg_d.interval_step    = cfg_wdata_i;
        nbdr_pkg::REG_RPS:   cfg_d.repeats_per_step = cfg_wdata_i[nbdr_pkg::ACCEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode             <= 1'b0;
      cfg_q.start_interval   <= nbdr_pkg::START_RST;
      cfg_q.floor_interval   <= nbdr_pkg::FLOOR_RST;
      cfg_q.interval_step    <= nbdr_pkg::STEP_RST;
      cfg_q.repeats_per_step <= nbdr_pkg::RPS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  nbdr_front #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_levels_i (raw_levels_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  nbdr_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  nbdr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (!fifo_empty),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .action_o     (action_o),
    .shifted_o    (shifted_o),
    .last_o       (last_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_full)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_empty)
    else $error("job popped from empty queue");

  a_shift_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shifted_o |->
      (action_o == nbdr_pkg::ACT_INC) || (action_o == nbdr_pkg::ACT_DEC) ||
      (action_o == nbdr_pkg::ACT_LEFT) || (action_o == nbdr_pkg::ACT_RIGHT))
    else $error("shift flag on non-directional action");

  a_action_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> action_o <= nbdr_pkg::ACT_SELECT)
    else $error("undefined action code");

endmodule

`default_nettype wire

>>> rtl/nbdr_front.sv
// Front end: takes a tick, debounces against the sample history, runs the
// hold and acceleration timers and turns the tick into an action job.
// Depends on nbdr_pkg.
`default_nettype none

module nbdr_front #(
  parameter int HISTORY_DEPTH = nbdr_pkg::HISTORY_DEPTH
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire nbdr_pkg::cfg_t         cfg_i,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire [nbdr_pkg::BTN_W-1:0]   raw_levels_i,
  input  wire                         fifo_full_i,
  output logic                        push_o,
  output nbdr_pkg::job_t              job_o
);

  logic [nbdr_pkg::BTN_W-1:0]      hist_q [HISTORY_DEPTH];
  logic [nbdr_pkg::BTN_W-1:0]      acc_q, acc_d;
  logic [nbdr_pkg::HOLD_W-1:0]     hold_q, hold_d;
  logic [nbdr_pkg::INTERVAL_W-1:0] int_q, int_d, new_int;
  logic [nbdr_pkg::ACCEL_W-1:0]    accel_q, accel_d;

  logic                            accept, bouncing, changed, expired, fire;
  logic                            rep, do_accel, sub_ok;
  logic [nbdr_pkg::BTN_W-1:0]      mask, b;
  logic [nbdr_pkg::INTERVAL_W:0]   diff;
  logic                            up, dn, en;
  nbdr_pkg::job_t                  job;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    mask = '1;
    if (cfg_i.mode) begin
      mask = '0;
      mask[nbdr_pkg::BTN_UP] = 1'b1;
      mask[nbdr_pkg::BTN_DN] = 1'b1;
      mask[nbdr_pkg::BTN_EN] = 1'b1;
    end
    b = ~raw_levels_i & mask;
    bouncing = 1'b0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (hist_q[i] != b) bouncing = 1'b1;
    end
  end

  assign changed = (b != acc_q);
  assign expired = (hold_q <= nbdr_pkg::HOLD_W'(1));
  assign fire    = changed || expired;
  assign up      = b[nbdr_pkg::BTN_UP];
  assign dn      = b[nbdr_pkg::BTN_DN];
  assign en      = b[nbdr_pkg::BTN_EN];

  always_comb begin
    job      = '0;
    rep      = 1'b0;
    do_accel = 1'b0;
    if (fire) begin
      if (cfg_i.mode) begin
        if (changed) begin
          if (en && up && dn) begin
            job.slots[nbdr_pkg::SLOT_BACK] = 1'b1;
            job.home = 1'b1;
          end else if (up && dn) begin
            job.slots[nbdr_pkg::SLOT_BACK] = 1'b1;
          end else if (en && dn) begin
            job.slots[nbdr_pkg::SLOT_LEFT] = 1'b1;
            job.sh = 1'b1;
          end else if (en && up) begin
            job.slots[nbdr_pkg::SLOT_RIGHT] = 1'b1;
          end else if (en) begin
            job.slots[nbdr_pkg::SLOT_SELECT] = 1'b1;
          end else if (dn) begin
            job.slots[nbdr_pkg::SLOT_DEC] = 1'b1;
            rep = 1'b1;
          end else if (up) begin
            job.slots[nbdr_pkg::SLOT_INC] = 1'b1;
            rep = 1'b1;
          end
        end else begin
          if (dn && !up && !en) begin
            job.slots[nbdr_pkg::SLOT_DEC] = 1'b1;
            rep = 1'b1;
          end else if (up && !dn && !en) begin
            job.slots[nbdr_pkg::SLOT_INC] = 1'b1;
            rep = 1'b1;
          end
        end
        do_accel = rep && expired;
      end else begin
        job.slots[nbdr_pkg::SLOT_INC]    = b[nbdr_pkg::BTN_UP];
        job.slots[nbdr_pkg::SLOT_DEC]    = b[nbdr_pkg::BTN_DN];
        job.slots[nbdr_pkg::SLOT_LEFT]   = b[nbdr_pkg::BTN_LF];
        job.slots[nbdr_pkg::SLOT_RIGHT]  = b[nbdr_pkg::BTN_RT];
        job.slots[nbdr_pkg::SLOT_SELECT] = b[nbdr_pkg::BTN_EN];
        job.slots[nbdr_pkg::SLOT_BACK]   = b[nbdr_pkg::BTN_BK];
        job.home = b[nbdr_pkg::BTN_SH];
        job.sh   = b[nbdr_pkg::BTN_SH];
        do_accel = expired;
      end
    end
  end

  // saturating interval step
  assign diff    = {1'b0, int_q} - {1'b0, cfg_i.interval_step};
  assign sub_ok  = !diff[nbdr_pkg::INTERVAL_W] &&
                   (diff[nbdr_pkg::INTERVAL_W-1:0] >= cfg_i.floor_interval);
  assign new_int = sub_ok ? diff[nbdr_pkg::INTERVAL_W-1:0] : cfg_i.floor_interval;

  always_comb begin
    acc_d   = acc_q;
    hold_d  = hold_q;
    int_d   = int_q;
    accel_d = accel_q;
    if (accept) begin
      if (bouncing) begin
        int_d   = cfg_i.start_interval;
        accel_d = cfg_i.repeats_per_step;
        hold_d  = {1'b0, cfg_i.start_interval};
      end else begin
        if (do_accel) begin
          if (accel_q <= nbdr_pkg::ACCEL_W'(1)) begin
            accel_d = cfg_i.repeats_per_step;
            int_d   = new_int;
          end else begin
            accel_d = accel_q - nbdr_pkg::ACCEL_W'(1);
          end
        end
        if (fire) acc_d = b;
        hold_d = expired ? {1'b0, int_d} : hold_q - nbdr_pkg::HOLD_W'(1);
      end
    end
  end

  assign push_o = accept && !bouncing && (|job.slots);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
      acc_q   <= '0;
      hold_q  <= '0;
      int_q   <= nbdr_pkg::START_RST;
      accel_q <= nbdr_pkg::RPS_RST;
    end else begin
      if (accept) begin
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) hist_q[i] <= hist_q[i+1];
        hist_q[HISTORY_DEPTH-1] <= b;
      end
      acc_q   <= acc_d;
      hold_q  <= hold_d;
      int_q   <= int_d;
      accel_q <= accel_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nbdr_fifo.sv
// Short job queue between the front end and the emitter.
// Depends on nbdr_pkg for the job type.
`default_nettype none

module nbdr_fifo #(
  parameter int DEPTH = nbdr_pkg::QUEUE_DEPTH
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire nbdr_pkg::job_t  data_i,
  input  wire                  pop_i,
  output nbdr_pkg::job_t       data_o,
  output logic                 empty_o,
  output logic                 full_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  nbdr_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    if (do_pop)  rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CNT_W'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nbdr_back.sv
// Emitter: walks a job's slot set in order, one action per cycle unless the
// output stalls, into a registered output stage. Depends on nbdr_pkg.
`default_nettype none

module nbdr_back (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            fifo_valid_i,
  input  wire nbdr_pkg::job_t            head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [nbdr_pkg::ACTION_W-1:0]  action_o,
  output logic                           shifted_o,
  output logic                           last_o
);

  nbdr_pkg::job_t                  cur_q, cur_d, eff;
  logic                            busy, advance;
  logic [nbdr_pkg::SLOT_W-1:0]     sel;
  logic [nbdr_pkg::NUM_SLOTS-1:0]  rest;
  logic                            out_valid_q, out_valid_d;
  logic [nbdr_pkg::ACTION_W-1:0]   action_q, action_d;
  logic                            shifted_q, shifted_d, last_q, last_d;

  assign busy    = |cur_q.slots;
  assign eff     = busy ? cur_q : (fifo_valid_i ? head_i : '0);
  assign advance = (|eff.slots) && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && !busy;

  always_comb begin
    sel = '0;
    for (int i = nbdr_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (eff.slots[i]) sel = nbdr_pkg::SLOT_W'(i);
    end
    rest      = eff.slots;
    rest[sel] = 1'b0;
  end

  always_comb begin
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    action_d    = action_q;
    shifted_d   = shifted_q;
    last_d      = last_q;
    if (advance) begin
      cur_d       = eff;
      cur_d.slots = rest;
      out_valid_d = 1'b1;
      action_d    = nbdr_pkg::slot_action(sel, eff.home);
      shifted_d   = (sel < nbdr_pkg::SLOT_SELECT) && eff.sh;
      last_d      = (rest == '0);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q  <= action_d;
    shifted_q <= shifted_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign action_o    = action_q;
  assign shifted_o   = shifted_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

>>> tb/sv/nav_action_checker.sv
// Scoreboard for nav_button_debounce_repeat_core: predicts the navigation actions of each
// transferred tick and compares them with the action transfers. Depends on nbdr_pkg.
`timescale 1ns / 1ps

module nav_action_checker (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [nbdr_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  wire [nbdr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire                            in_valid_i,
  input  wire                            in_ready_i,
  input  wire [nbdr_pkg::BTN_W-1:0]      raw_levels_i,
  input  wire                            out_valid_i,
  input  wire                            out_ready_i,
  input  wire [nbdr_pkg::ACTION_W-1:0]   action_i,
  input  wire                            shifted_i,
  input  wire                            last_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import nbdr_pkg::*;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                shifted;
    logic                last;
  } nav_action_t;

  localparam logic [BTN_W-1:0] THREE_MASK = (7'b1 << BTN_UP) | (7'b1 << BTN_DN) |
                                            (7'b1 << BTN_EN);

  cfg_t                  cfg;
  logic [BTN_W-1:0]      history [HISTORY_DEPTH];
  logic [BTN_W-1:0]      accepted;
  logic [HOLD_W-1:0]     hold_cnt;
  logic [INTERVAL_W-1:0] interval;
  logic [ACCEL_W-1:0]    accel_cnt;

  nav_action_t expected_actions[$];
  nav_action_t tick_actions [NUM_SLOTS];
  int          tick_n;
  nav_action_t front_action;
  int          fails;

  function automatic void add_action(input logic [ACTION_W-1:0] act, input logic sh);
    tick_actions[tick_n] = '{action: act, shifted: sh, last: 1'b0};
    tick_n++;
  endfunction

  function automatic void accelerate();
    if (accel_cnt <= 1) begin
      accel_cnt = cfg.repeats_per_step;
      if (interval >= cfg.interval_step &&
          interval - cfg.interval_step >= cfg.floor_interval)
        interval = interval - cfg.interval_step;
      else
        interval = cfg.floor_interval;
    end else begin
      accel_cnt = accel_cnt - 1'b1;
    end
  endfunction

  function automatic void predict_tick(input logic [BTN_W-1:0] raw);
    logic [BTN_W-1:0] b;
    logic bouncing, changed, expired, up, dn, en, rep, sh;
    b = ~raw & (cfg.mode ? THREE_MASK : {BTN_W{1'b1}});
    bouncing = 1'b0;
    for (int i = 0; i < HISTORY_DEPTH; i++)
      if (history[i] != b) bouncing = 1'b1;
    for (int i = 1; i < HISTORY_DEPTH; i++)
      history[i-1] = history[i];
    history[HISTORY_DEPTH-1] = b;
    tick_n = 0;
    if (bouncing) begin
      interval  = cfg.start_interval;
      hold_cnt  = {1'b0, cfg.start_interval};
      accel_cnt = cfg.repeats_per_step;
      return;
    end
    changed = (b != accepted);
    expired = (hold_cnt <= 1);
    if (changed || expired) begin
      if (cfg.mode) begin
        up  = b[BTN_UP];
        dn  = b[BTN_DN];
        en  = b[BTN_EN];
        rep = 1'b0;
        if (changed) begin
          if (en && up && dn) add_action(ACT_HOME, 1'b0);
          else if (up && dn) add_action(ACT_BACK, 1'b0);
          else if (en && dn) add_action(ACT_LEFT, 1'b1);
          else if (en && up) add_action(ACT_RIGHT, 1'b0);
          else if (en) add_action(ACT_SELECT, 1'b0);
          else if (dn) begin
            add_action(ACT_DEC, 1'b0);
            rep = 1'b1;
          end else if (up) begin
            add_action(ACT_INC, 1'b0);
            rep = 1'b1;
          end
        end else if (dn && !up && !en) begin
          add_action(ACT_DEC, 1'b0);
          rep = 1'b1;
        end else if (up && !dn && !en) begin
          add_action(ACT_INC, 1'b0);
          rep = 1'b1;
        end
        if (rep && expired) accelerate();
      end else begin
        sh = b[BTN_SH];
        if (b[BTN_UP]) add_action(ACT_INC, sh);
        if (b[BTN_DN]) add_action(ACT_DEC, sh);
        if (b[BTN_LF]) add_action(ACT_LEFT, sh);
        if (b[BTN_RT]) add_action(ACT_RIGHT, sh);
        if (b[BTN_EN]) add_action(ACT_SELECT, 1'b0);
        if (b[BTN_BK]) add_action(sh ? ACT_HOME : ACT_BACK, 1'b0);
        if (expired) accelerate();
      end
      accepted = b;
    end
    if (hold_cnt <= 1) hold_cnt = {1'b0, interval};
    else hold_cnt = hold_cnt - 1'b1;
    for (int i = 0; i < tick_n; i++) begin
      if (i == tick_n - 1) tick_actions[i].last = 1'b1;
      expected_actions.push_back(tick_actions[i]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.mode             = 1'b0;
      cfg.start_interval   = START_RST;
      cfg.floor_interval   = FLOOR_RST;
      cfg.interval_step    = STEP_RST;
      cfg.repeats_per_step = RPS_RST;
      for (int i = 0; i < HISTORY_DEPTH; i++) history[i] = '0;
      accepted  = '0;
      hold_cnt  = '0;
      interval  = START_RST;
      accel_cnt = RPS_RST;
      expected_actions.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_actions.size() == 0) begin
          $error("action transfer with nothing expected: action %0d shifted %0d last %0d",
                 action_i, shifted_i, last_i);
          fails++;
        end else begin
          front_action = expected_actions.pop_front();
          if (action_i !== front_action.action) begin
            $error("action: expected %0d, got %0d", front_action.action, action_i);
            fails++;
          end
          if (shifted_i !== front_action.shifted) begin
            $error("shifted: expected %0d, got %0d", front_action.shifted, shifted_i);
            fails++;
          end
          if (last_i !== front_action.last) begin
            $error("last: expected %0d, got %0d", front_action.last, last_i);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:  cfg.mode             = cfg_wdata_i[0];
          REG_START: cfg.start_interval   = cfg_wdata_i;
          REG_FLOOR: cfg.floor_interval   = cfg_wdata_i;
          REG_STEP:  cfg.interval_step    = cfg_wdata_i;
          REG_RPS:   cfg.repeats_per_step = cfg_wdata_i[ACCEL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_tick(raw_levels_i);
    end
    fail_count_o <= fails;
    pending_o    <= expected_actions.size();
  end

endmodule

>>> tb/sv/nav_button_debounce_repeat_core_test.sv
// Top of the testbench for nav_button_debounce_repeat_core: clock, reset, tick stimulus,
// register phases and random stalls; checking is done by nav_action_checker.
// Depends on nbdr_pkg, the block and nav_action_checker.
`timescale 1ns / 1ps

module nav_button_debounce_repeat_core_test;
  import nbdr_pkg::*;

  localparam int SETTLE_CYCLES = 32;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  tick_valid;
  logic                  tick_ready;
  logic [BTN_W-1:0]      raw_levels;
  logic                  act_valid;
  logic                  act_ready = 1'b0;
  logic [ACTION_W-1:0]   action;
  logic                  shifted;
  logic                  last;
  int                    fail_count;
  int                    pending;
  bit                    tx_idle = 1'b0;
  bit                    rx_stall = 1'b0;

  nav_button_debounce_repeat_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (tick_valid),
    .in_ready_o   (tick_ready),
    .raw_levels_i (raw_levels),
    .out_valid_o  (act_valid),
    .out_ready_i  (act_ready),
    .action_o     (action),
    .shifted_o    (shifted),
    .last_o       (last)
  );

  nav_action_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (tick_valid),
    .in_ready_i   (tick_ready),
    .raw_levels_i (raw_levels),
    .out_valid_i  (act_valid),
    .out_ready_i  (act_ready),
    .action_i     (action),
    .shifted_i    (shifted),
    .last_i       (last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // idle share in percent: lower when both sides stall
  function automatic int idle_pct();
    return (tx_idle && rx_stall) ? 36 : 69;
  endfunction

  always @(posedge clk) begin
    act_ready <= !(rx_stall && $urandom_range(99) < idle_pct());
  end

  task automatic send_tick(input logic [BTN_W-1:0] raw);
    if (tx_idle && $urandom_range(99) < idle_pct()) begin
      tick_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct());
    end
    tick_valid <= 1'b1;
    raw_levels <= raw;
    do @(posedge clk); while (!tick_ready);
  endtask

  task automatic send_run(input logic [BTN_W-1:0] raw, input int count);
    repeat (count) send_tick(raw);
  endtask

  // drain all expected actions, then let queued empty ticks finish
  task automatic settle();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  function automatic logic [BTN_W-1:0] pick_buttons(input logic mode);
    logic [BTN_W-1:0] sel;
    if (mode) begin
      case ($urandom_range(9))
        0:       sel = '0;
        1, 2:    sel = 7'b1 << BTN_UP;
        3, 4:    sel = 7'b1 << BTN_DN;
        5:       sel = 7'b1 << BTN_EN;
        6:       sel = (7'b1 << BTN_UP) | (7'b1 << BTN_DN);
        7:       sel = (7'b1 << BTN_EN) | (7'b1 << BTN_UP);
        8:       sel = (7'b1 << BTN_EN) | (7'b1 << BTN_DN);
        default: sel = (7'b1 << BTN_UP) | (7'b1 << BTN_DN) | (7'b1 << BTN_EN);
      endcase
    end else begin
      case ($urandom_range(9))
        0:       sel = '0;
        1, 2, 3: sel = 7'b1 << $urandom_range(BTN_SH);
        4:       sel = (7'b1 << BTN_SH) | (7'b1 << $urandom_range(BTN_BK));
        default: sel = BTN_W'($urandom);
      endcase
    end
    return sel;
  endfunction

  task automatic run_phase(input logic mode, input logic [INTERVAL_W-1:0] start_v,
                           input logic [INTERVAL_W-1:0] floor_v,
                           input logic [INTERVAL_W-1:0] step_v,
                           input logic [ACCEL_W-1:0] rps_v, input int n_ticks,
                           input bit tx, input bit rx);
    int               sent;
    int               len;
    logic [BTN_W-1:0] pressed;
    logic [BTN_W-1:0] keep;
    settle();
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    write_reg(REG_START, start_v);
    write_reg(REG_FLOOR, floor_v);
    write_reg(REG_STEP, step_v);
    write_reg(REG_RPS, CFG_DATA_W'(rps_v));
    write_reg(REG_IDX_W'(REG_RPS + $urandom_range(1, 3)), CFG_DATA_W'($urandom));
    cfg_we   <= 1'b0;
    tx_idle  = tx;
    rx_stall = rx;
    keep = mode ? ((7'b1 << BTN_UP) | (7'b1 << BTN_DN) | (7'b1 << BTN_EN)) : {BTN_W{1'b1}};
    sent = 0;
    while (sent < n_ticks) begin
      if ($urandom_range(99) < 80) begin
        pressed = pick_buttons(mode);
        len = $urandom_range(5, 24);
        if (len > n_ticks - sent) len = n_ticks - sent;
        repeat (len) begin
          // masked-off bits toggle freely in chord mode
          send_tick(~pressed ^ (BTN_W'($urandom) & ~keep));
          sent++;
        end
      end else begin
        len = $urandom_range(1, 3);
        if (len > n_ticks - sent) len = n_ticks - sent;
        repeat (len) begin
          send_tick(BTN_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    tick_valid <= 1'b0;
    raw_levels <= '1;
    cfg_we     <= 1'b0;
    cfg_idx    <= REG_MODE;
    cfg_wdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: idle levels, all pressed, back alone, shift alone, bounce then up
    send_run(7'h7F, 2);
    send_run(7'h00, 5);
    send_run(~(7'b1 << BTN_BK), 5);
    send_run(~(7'b1 << BTN_SH), 5);
    send_run(7'h7F, 1);
    send_run(~(7'b1 << BTN_UP), 5);

    run_phase(1'b0, 10'd8, 10'd2, 10'd3, 4'd2, 60, 1'b0, 1'b0);
    run_phase(1'b1, 10'd6, 10'd1, 10'd1, 4'd1, 60, 1'b1, 1'b0);
    run_phase(1'b0, 10'd1023, 10'd1023, 10'd0, 4'd15, 45, 1'b0, 1'b1);
    run_phase(1'b1, 10'd1, 10'd1, 10'd1023, 4'd15, 50, 1'b1, 1'b1);
    // zero start interval, below the floor
    run_phase(1'b1, 10'd0, 10'd5, 10'd2, 4'd3, 50, 1'b0, 1'b1);
    run_phase(1'b0, START_RST, FLOOR_RST, STEP_RST, RPS_RST, 45, 1'b1, 1'b0);
    run_phase(1'($urandom), INTERVAL_W'($urandom_range(2, 40)),
              INTERVAL_W'($urandom_range(1, 10)), INTERVAL_W'($urandom_range(0, 15)),
              ACCEL_W'($urandom_range(1, 15)), 60, 1'b1, 1'b1);

    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
